// File: rtl/ssml_pkg.sv
package ssml_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int LEN_W = ADDR_W + 1;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUF_DEPTH);

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_SEND_CODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FETCH_CODE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DONE_CODE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_CODE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BUF_LIMIT = 3'd4;

	localparam logic [31:0] SEND_CODE_RST = 32'd1;
	localparam logic [31:0] FETCH_CODE_RST = 32'd2;
	localparam logic [31:0] DONE_CODE_RST = 32'd0;
	localparam logic [31:0] ERROR_CODE_RST = 32'd255;
	localparam logic [5:0] BUF_LIMIT_RST = 6'd20;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_NO_MSG = 2'd2;

	typedef enum logic [1:0] {
		OP_WORD = 2'd0,
		OP_CS = 2'd1,
		OP_TX_WR = 2'd2,
		OP_RX_RD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_SEND = 3'b010,
		MODE_RECV = 3'b100
	} mode_t;

	typedef struct packed {
		logic [31:0] send_code;
		logic [31:0] fetch_code;
		logic [31:0] done_code;
		logic [31:0] error_code;
		logic [5:0] buf_limit;
	} cfg_t;

	typedef struct packed {
		op_t op;
		logic [31:0] word;
		logic cs_level;
		logic [7:0] data;
		logic [ADDR_W-1:0] index;
		logic last;
	} item_t;

endpackage

// File: rtl/ssml_in_if.sv
interface ssml_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [31:0] word;
	logic cs_level;
	logic [7:0] data;
	logic [ssml_pkg::ADDR_W-1:0] index;
	logic last;

	modport source(output valid, op, word, cs_level, data, index, last, input ready);
	modport sink(input valid, op, word, cs_level, data, index, last, output ready);
endinterface

// File: rtl/ssml_out_if.sv
interface ssml_out_if;
	logic valid;
	logic ready;
	logic [31:0] miso_word;
	logic miso_loaded;
	logic irq_level;
	logic miso_drive;
	logic [7:0] rx_byte;
	logic [5:0] rx_count;
	logic [5:0] tx_pending;
	logic [1:0] status;

	modport source(output valid, miso_word, miso_loaded, irq_level, miso_drive, rx_byte,
		rx_count, tx_pending, status, input ready);
	modport sink(input valid, miso_word, miso_loaded, irq_level, miso_drive, rx_byte,
		rx_count, tx_pending, status, output ready);
endinterface

// File: rtl/ssml_cfg_if.sv
interface ssml_cfg_if;
	logic valid;
	logic ready;
	logic [ssml_pkg::REG_IDX_W-1:0] index;
	logic [31:0] wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// File: rtl/ssml_cfg_regs.sv
module ssml_cfg_regs (
	input logic clk,
	input logic arst_n,
	ssml_cfg_if.sink cfg,
	output ssml_pkg::cfg_t cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.send_code <= ssml_pkg::SEND_CODE_RST;
			cfg_q.fetch_code <= ssml_pkg::FETCH_CODE_RST;
			cfg_q.done_code <= ssml_pkg::DONE_CODE_RST;
			cfg_q.error_code <= ssml_pkg::ERROR_CODE_RST;
			cfg_q.buf_limit <= ssml_pkg::BUF_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ssml_pkg::REG_SEND_CODE: cfg_q.send_code <= cfg.wdata;
				ssml_pkg::REG_FETCH_CODE: cfg_q.fetch_code <= cfg.wdata;
				ssml_pkg::REG_DONE_CODE: cfg_q.done_code <= cfg.wdata;
				ssml_pkg::REG_ERROR_CODE: cfg_q.error_code <= cfg.wdata;
				ssml_pkg::REG_BUF_LIMIT: cfg_q.buf_limit <= cfg.wdata[5:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/ssml_engine.sv
module ssml_engine (
	input logic clk,
	input logic arst_n,
	input ssml_pkg::cfg_t cfg_q,
	ssml_in_if.sink in_ch,
	ssml_out_if.source out_ch
);

	localparam int AW = ssml_pkg::ADDR_W;
	localparam int LW = ssml_pkg::LEN_W;

	// input stage
	logic s1_valid_q;
	ssml_pkg::item_t item_s1;
	logic [7:0] rx_rd_s1;

	// message state
	ssml_pkg::mode_t mode_q, mode_d;
	logic [LW-1:0] rx_len_q, rx_len_d;
	logic [LW-1:0] tx_len_q, tx_len_d;
	logic [LW-1:0] tx_pos_q, tx_pos_d;
	logic irq_q, irq_d;
	logic drive_q, drive_d;
	logic [31:0] reply_q, reply_d;

	// stores
	logic [7:0] rx_mem [ssml_pkg::BUF_DEPTH];
	logic [7:0] tx_mem [ssml_pkg::BUF_DEPTH];
	logic [7:0] tx_head_q;
	logic rx_we, tx_we;
	logic [AW-1:0] rx_wa, tx_wa, tx_ra;
	logic [7:0] rx_wd, tx_wd;

	// result stage
	logic out_valid_q;
	logic loaded_d, loaded_q;
	logic [7:0] rxb_d, rxb_q;
	logic [1:0] status_d, status_q;

	logic adv, in_fire;
	logic [LW-1:0] lim, commit_n, commit_len;
	logic nt_take, nt_end;
	logic [31:0] nt_word;

	assign adv = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid_q || adv;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.op <= ssml_pkg::op_t'(in_ch.op);
			item_s1.word <= in_ch.word;
			item_s1.cs_level <= in_ch.cs_level;
			item_s1.data <= in_ch.data;
			item_s1.index <= in_ch.index;
			item_s1.last <= in_ch.last;
		end
	end

	// rx store: read at accept time, write-first against the item in flight
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wa] <= rx_wd;
		end
		if (in_fire) begin
			rx_byte_rd: begin
				if (rx_we && rx_wa == in_ch.index) rx_rd_s1 <= rx_wd;
				else rx_rd_s1 <= rx_mem[in_ch.index];
			end
		end
	end

	// tx store: head byte prefetched at the next stream position
	assign tx_ra = tx_pos_d[AW-1:0];

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wa] <= tx_wd;
		end
		if (tx_we && tx_wa == tx_ra) tx_head_q <= tx_wd;
		else tx_head_q <= tx_mem[tx_ra];
	end

	assign lim = (cfg_q.buf_limit > ssml_pkg::DEPTH_LEN) ? ssml_pkg::DEPTH_LEN : cfg_q.buf_limit;
	assign commit_n = {1'b0, item_s1.index} + LW'(1);
	assign commit_len = (commit_n > lim) ? lim : commit_n;

	assign nt_take = tx_pos_q < tx_len_q;
	assign nt_word = nt_take ? {24'd0, tx_head_q} : cfg_q.done_code;
	assign nt_end = nt_word == cfg_q.done_code;

	always_comb begin
		mode_d = mode_q;
		rx_len_d = rx_len_q;
		tx_len_d = tx_len_q;
		tx_pos_d = tx_pos_q;
		irq_d = irq_q;
		drive_d = drive_q;
		reply_d = reply_q;
		loaded_d = 1'b0;
		rxb_d = 8'd0;
		status_d = ssml_pkg::ST_OK;
		rx_we = 1'b0;
		rx_wa = rx_len_q[AW-1:0];
		rx_wd = item_s1.word[7:0];
		tx_we = 1'b0;
		tx_wa = item_s1.index;
		tx_wd = item_s1.data;
		if (adv) begin
			unique case (item_s1.op)
				ssml_pkg::OP_WORD: begin
					unique case (mode_q)
						ssml_pkg::MODE_IDLE: begin
							loaded_d = 1'b1;
							if (item_s1.word == cfg_q.send_code) begin
								mode_d = ssml_pkg::MODE_SEND;
								rx_len_d = '0;
								reply_d = 32'd0;
							end else if (item_s1.word == cfg_q.fetch_code) begin
								reply_d = nt_word;
								if (nt_take) tx_pos_d = tx_pos_q + LW'(1);
								if (nt_end) begin
									tx_pos_d = '0;
									tx_len_d = '0;
									mode_d = ssml_pkg::MODE_IDLE;
								end else begin
									mode_d = ssml_pkg::MODE_RECV;
								end
							end else begin
								reply_d = cfg_q.error_code;
							end
						end
						ssml_pkg::MODE_SEND: begin
							if (item_s1.word == cfg_q.done_code) begin
								mode_d = ssml_pkg::MODE_IDLE;
							end else begin
								if (rx_len_q < lim) begin
									rx_we = 1'b1;
									rx_len_d = rx_len_q + LW'(1);
								end
								reply_d = item_s1.word;
								loaded_d = 1'b1;
							end
						end
						default: begin
							loaded_d = 1'b1;
							if (item_s1.word == cfg_q.done_code) begin
								mode_d = ssml_pkg::MODE_IDLE;
								reply_d = 32'd0;
							end else begin
								reply_d = nt_word;
								if (nt_take) tx_pos_d = tx_pos_q + LW'(1);
								if (nt_end) begin
									tx_pos_d = '0;
									tx_len_d = '0;
									mode_d = ssml_pkg::MODE_IDLE;
								end
							end
						end
					endcase
				end
				ssml_pkg::OP_CS: begin
					if (!item_s1.cs_level) begin
						drive_d = 1'b1;
						irq_d = 1'b1;
					end else begin
						drive_d = 1'b0;
						mode_d = ssml_pkg::MODE_IDLE;
						irq_d = (tx_len_q == '0);
					end
				end
				ssml_pkg::OP_TX_WR: begin
					if (tx_len_q != '0) begin
						status_d = ssml_pkg::ST_BUSY;
					end else begin
						tx_we = 1'b1;
						if (item_s1.last && commit_len != '0) begin
							tx_len_d = commit_len;
							tx_pos_d = '0;
							irq_d = 1'b0;
						end
					end
				end
				ssml_pkg::OP_RX_RD: begin
					if (mode_q == ssml_pkg::MODE_IDLE && rx_len_q != '0
						&& {1'b0, item_s1.index} < rx_len_q) begin
						rxb_d = rx_rd_s1;
						if (item_s1.last) rx_len_d = '0;
					end else begin
						status_d = ssml_pkg::ST_NO_MSG;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ssml_pkg::MODE_IDLE;
			rx_len_q <= '0;
			tx_len_q <= '0;
			tx_pos_q <= '0;
			irq_q <= 1'b1;
			drive_q <= 1'b0;
			reply_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			rx_len_q <= rx_len_d;
			tx_len_q <= tx_len_d;
			tx_pos_q <= tx_pos_d;
			irq_q <= irq_d;
			drive_q <= drive_d;
			reply_q <= reply_d;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			loaded_q <= loaded_d;
			rxb_q <= rxb_d;
			status_q <= status_d;
		end
	end

	// state registers already hold this beat's values once it is registered
	assign out_ch.valid = out_valid_q;
	assign out_ch.miso_word = reply_q;
	assign out_ch.miso_loaded = loaded_q;
	assign out_ch.irq_level = irq_q;
	assign out_ch.miso_drive = drive_q;
	assign out_ch.rx_byte = rxb_q;
	assign out_ch.rx_count = 6'(rx_len_q);
	assign out_ch.tx_pending = 6'(tx_len_q);
	assign out_ch.status = status_q;

endmodule

// File: rtl/spi_slave_message_link_core.sv
// SPI slave message link.
// in_ch  : one beat per event - a 32-bit SPI word from the master, a chip-select
//          level change, a local write of one transmit byte, or a local read of
//          one receive byte.
// out_ch : exactly one beat per input beat, in order: the loaded reply word,
//          interrupt and pin-drive levels, read byte, store lengths and status.
// cfg    : register writes (send, fetch, done and error codes, buffer limit),
//          always ready; write only while no beat is in flight.
// Path: an accepted input beat is held in the input register, is processed when
// it advances into the result register, and is presented on out_ch from there.
// Throughput: one beat per cycle while out_ch is not held; an input register and
// a result register keep both sides decoupled, and the transmit store prefetches
// the next stream byte so each beat is a single compare-and-update pass.
// Reset: mode idle, store lengths zero, interrupt high, pin released, reply
// word zero, no beat held. Stores need no clearing.
// Stall: while out_ch is held, the result register keeps its beat, the input
// register takes one more beat and then in_ch ready drops.
module spi_slave_message_link_core (
	input logic clk,
	input logic arst_n,
	ssml_in_if.sink in_ch,
	ssml_out_if.source out_ch,
	ssml_cfg_if.sink cfg
);

	ssml_pkg::cfg_t cfg_q;

	ssml_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cfg_q(cfg_q)
	);

	ssml_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_q(cfg_q),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

endmodule

// File: rtl/ssml_checker.sv
module ssml_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] miso_word,
	input logic miso_loaded,
	input logic [1:0] status
);

	logic [1:0] cnt_q;
	logic [31:0] last_word_q;
	logic in_beat, out_beat;

	assign in_beat = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			last_word_q <= 32'd0;
		end else begin
			cnt_q <= cnt_q + 2'(in_beat) - 2'(out_beat);
			if (out_beat) last_word_q <= miso_word;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(miso_word) && $stable(status))
		else $error("result beat changed while stalled");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 || cnt_q == 2'd1 || cnt_q == 2'd2)
		else $error("more than two beats in flight");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 2'd0)
		else $error("result beat without an input beat");

	a_reply_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !miso_loaded |-> miso_word == last_word_q)
		else $error("reply word changed without a load");

endmodule

bind spi_slave_message_link_core ssml_checker u_ssml_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.miso_word(out_ch.miso_word),
	.miso_loaded(out_ch.miso_loaded),
	.status(out_ch.status)
);
